### src/njs_pkg.sv
// njs_pkg: shared types and constants of the job scheduler
// used by njs_cell, njs_run and nonpreemptive_job_scheduler; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package njs_pkg;

  localparam int IdW    = 8;
  localparam int BurstW = 16;
  localparam int ClkW   = 32;
  localparam int SumW   = 48;
  localparam int CntW   = 32;

  typedef enum logic {
    FUNC_SUBMIT = 1'b0,
    FUNC_TICK   = 1'b1
  } func_t;

  typedef enum logic {
    ST_DONE   = 1'b0,
    ST_REJECT = 1'b1
  } status_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    logic [ClkW-1:0]   arrival;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    logic [ClkW-1:0]   wait_time;
    logic [ClkW-1:0]   turnaround;
  } fin_t;

endpackage

`default_nettype wire

### src/nonpreemptive_job_scheduler.sv
// nonpreemptive_job_scheduler: longest-job-first scheduler, top level
// row of njs_cell slots, njs_run for the running job, result stage; uses njs_pkg
//
//  channel | dir | tuser            | tdata (lowest bit up)
//  in_     | in  | func             | job_id, burst
//  out_    | out | status           | done_id, done_burst, wait_time, turnaround,
//          |     |                  | total_wait, total_turnaround, jobs_done
//
// a submit or a tick is taken while in_tready is high: the cell row inserts or shifts in one step
// an item with a result (a reject or a finished job) holds it in the result stage; the totals
// add for a finished job as it moves on into the output register; in_tready is low while that
// stage holds a result, which stays there while out_tready is low and the output register is full
// reset clears the clock, the run state, the totals and the valid bit of every cell
`timescale 1ns / 1ps
`default_nettype none

module nonpreemptive_job_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [0:0]   in_tuser,   // func
  input  wire logic [23:0]  in_tdata,   // job_id, burst
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [0:0]        out_tuser,  // status
  output logic [215:0]      out_tdata   // done_id, done_burst, wait_time, turnaround,
                                        // total_wait, total_turnaround, jobs_done
);

  njs_pkg::func_t  func;
  logic            accept, submit, tick, full, ins, reject, pop, run_done;
  njs_pkg::entry_t new_ent, stamp;
  njs_pkg::fin_t   run_fin, fin_r, fin_nxt;
  logic            fin_valid_r, fin_valid_nxt, move;

  njs_pkg::entry_t          cell_ent   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_valid;
  logic [QUEUE_DEPTH-1:0]   cell_keep;

  logic [njs_pkg::SumW-1:0] sw_r, sw_nxt, st_r, st_nxt;
  logic [njs_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [0:0]               out_user_r, out_user_nxt;
  logic [215:0]             out_data_r, out_data_nxt;

  assign in_tready = !fin_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign func      = njs_pkg::func_t'(in_tuser);
  assign submit    = accept && (func == njs_pkg::FUNC_SUBMIT);
  assign tick      = accept && (func == njs_pkg::FUNC_TICK);
  assign full      = cell_valid[QUEUE_DEPTH-1];
  assign ins       = submit && !full;
  assign reject    = submit && full;

  assign new_ent = '{id: in_tdata[7:0], burst: in_tdata[23:8], arrival: stamp.arrival};

  njs_run u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .head       (cell_ent[0]),
    .head_valid (cell_valid[0]),
    .clk_stamp  (stamp),
    .dispatch   (pop),
    .done       (run_done),
    .fin        (run_fin)
  );

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    njs_pkg::entry_t prev_ent, next_ent;
    logic            prev_valid, prev_keep, next_valid;
    if (k == 0) begin : g_first
      assign prev_ent   = new_ent;
      assign prev_valid = 1'b0;
      assign prev_keep  = 1'b1;
    end else begin : g_mid
      assign prev_ent   = cell_ent[k-1];
      assign prev_valid = cell_valid[k-1];
      assign prev_keep  = cell_keep[k-1];
    end
    if (k == QUEUE_DEPTH-1) begin : g_last
      assign next_ent   = cell_ent[k];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_ent   = cell_ent[k+1];
      assign next_valid = cell_valid[k+1];
    end
    njs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ins        (ins),
      .pop        (pop),
      .new_ent    (new_ent),
      .prev_ent   (prev_ent),
      .prev_valid (prev_valid),
      .prev_keep  (prev_keep),
      .next_ent   (next_ent),
      .next_valid (next_valid),
      .ent        (cell_ent[k]),
      .valid      (cell_valid[k]),
      .keep       (cell_keep[k])
    );
  end

  always_comb begin
    fin_nxt       = fin_r;
    fin_valid_nxt = fin_valid_r;
    move          = fin_valid_r && (!out_valid_r || out_tready);
    if (move) begin
      fin_valid_nxt = 1'b0;
    end
    if (reject) begin
      fin_nxt.status     = njs_pkg::ST_REJECT;
      fin_nxt.id         = in_tdata[7:0];
      fin_nxt.burst      = in_tdata[23:8];
      fin_nxt.wait_time  = '0;
      fin_nxt.turnaround = '0;
      fin_valid_nxt      = 1'b1;
    end else if (run_done) begin
      fin_nxt       = run_fin;
      fin_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    sw_nxt        = sw_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (move) begin
      if (fin_r.status == njs_pkg::ST_DONE) begin
        sw_nxt  = sw_r + {{(njs_pkg::SumW-njs_pkg::ClkW){1'b0}}, fin_r.wait_time};
        st_nxt  = st_r + {{(njs_pkg::SumW-njs_pkg::ClkW){1'b0}}, fin_r.turnaround};
        cnt_nxt = cnt_r + 1'b1;
      end
      out_valid_nxt = 1'b1;
      out_user_nxt  = fin_r.status;
      out_data_nxt  = {cnt_nxt, st_nxt, sw_nxt, fin_r.turnaround, fin_r.wait_time,
                       fin_r.burst, fin_r.id};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      sw_r        <= '0;
      st_r        <= '0;
      cnt_r       <= '0;
    end else begin
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sw_r        <= sw_nxt;
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r      <= fin_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & ~{cell_valid[QUEUE_DEPTH-2:0], 1'b1}) == '0)
    else $error("queue cells not packed from the head");

  a_no_insert_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ins && pop))
    else $error("insert and dispatch in the same cycle");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid_r && out_valid_r && !out_tready |=> fin_valid_r && $stable(fin_r))
    else $error("pending result lost under stall");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cell_valid[0] && tick)
    else $error("dispatch from an empty queue");
`endif

endmodule

`default_nettype wire

### src/njs_cell.sv
// njs_cell: one slot of the ready queue, ordered by descending burst
// shifts towards its neighbours on insert and on dispatch; depends on njs_pkg
`timescale 1ns / 1ps
`default_nettype none

module njs_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ins,
  input  wire logic          pop,
  input  wire njs_pkg::entry_t new_ent,
  input  wire njs_pkg::entry_t prev_ent,
  input  wire logic          prev_valid,
  input  wire logic          prev_keep,
  input  wire njs_pkg::entry_t next_ent,
  input  wire logic          next_valid,
  output njs_pkg::entry_t    ent,
  output logic               valid,
  output logic               keep
);

  njs_pkg::entry_t ent_r, ent_nxt;
  logic            valid_r, valid_nxt;

  always_comb begin
    keep      = valid_r && (ent_r.burst >= new_ent.burst);
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    if (pop) begin
      ent_nxt   = next_ent;
      valid_nxt = next_valid;
    end else if (ins && !keep) begin
      if (prev_keep) begin
        ent_nxt   = new_ent;
        valid_nxt = 1'b1;
      end else begin
        ent_nxt   = prev_ent;
        valid_nxt = prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent   = ent_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

### src/njs_run.sv
// njs_run: scheduler clock and the running job, dispatch and completion
// takes the queue head from the cell row; depends on njs_pkg
`timescale 1ns / 1ps
`default_nettype none

module njs_run (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            tick,
  input  wire njs_pkg::entry_t head,
  input  wire logic            head_valid,
  output njs_pkg::entry_t      clk_stamp,
  output logic                 dispatch,
  output logic                 done,
  output njs_pkg::fin_t        fin
);

  logic [njs_pkg::ClkW-1:0]   now_r, now_nxt, nowp1_r, nowp1_nxt;
  logic                       busy_r, busy_nxt;
  logic [njs_pkg::IdW-1:0]    id_r, id_nxt;
  logic [njs_pkg::BurstW-1:0] burst_r, burst_nxt;
  logic [njs_pkg::BurstW-1:0] rem_r, rem_nxt, cur_rem;
  logic [njs_pkg::ClkW-1:0]   wait_r, wait_nxt;
  logic [njs_pkg::ClkW-1:0]   ta_r, ta_nxt;
  logic                       active;

  always_comb begin
    dispatch  = tick && !busy_r && head_valid;
    active    = dispatch || busy_r;
    id_nxt    = id_r;
    burst_nxt = burst_r;
    wait_nxt  = wait_r;
    ta_nxt    = ta_r;
    rem_nxt   = rem_r;
    busy_nxt  = busy_r;
    now_nxt   = now_r;
    nowp1_nxt = nowp1_r;
    cur_rem   = rem_r;
    if (dispatch) begin
      id_nxt    = head.id;
      burst_nxt = head.burst;
      cur_rem   = head.burst;
      wait_nxt  = now_r - head.arrival;
      ta_nxt    = nowp1_r - head.arrival;
    end else begin
      ta_nxt    = ta_r + 1'b1;
    end
    // saturating countdown
    rem_nxt = (cur_rem == '0) ? '0 : cur_rem - 1'b1;
    done    = tick && active && (rem_nxt == '0);
    if (tick) begin
      now_nxt   = nowp1_r;
      nowp1_nxt = nowp1_r + 1'b1;
      if (active) begin
        busy_nxt = !done;
      end
    end
    if (!(tick && active)) begin
      id_nxt    = id_r;
      burst_nxt = burst_r;
      wait_nxt  = wait_r;
      ta_nxt    = ta_r;
      rem_nxt   = rem_r;
    end
    fin.status     = njs_pkg::ST_DONE;
    fin.id         = id_nxt;
    fin.burst      = burst_nxt;
    fin.wait_time  = wait_nxt;
    fin.turnaround = ta_nxt;
    clk_stamp      = '{id: '0, burst: '0, arrival: now_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= '0;
      nowp1_r <= {{(njs_pkg::ClkW-1){1'b0}}, 1'b1};
      busy_r  <= 1'b0;
    end else begin
      now_r   <= now_nxt;
      nowp1_r <= nowp1_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    burst_r <= burst_nxt;
    rem_r   <= rem_nxt;
    wait_r  <= wait_nxt;
    ta_r    <= ta_nxt;
  end

endmodule

`default_nettype wire
